// ----- rtl/msp_pkg.sv -----
// Shared types, widths and constants of the mode-switching speed PI controller.
package msp_pkg;

  // Field widths
  localparam int SPEED_W   = 16;
  localparam int DESIRED_W = SPEED_W - 1;
  localparam int TIME_W    = 32;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int LEVEL_W   = 16;
  localparam int MODE_W    = 2;
  localparam int REG_W     = 16;

  localparam int IN_DATA_W  = ((DESIRED_W + SPEED_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * LEVEL_W + MODE_W + 7) / 8) * 8;

  // Register file
  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = $clog2(CFG_NUM);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_KP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_KI    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_KP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_KI    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_EXIT  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_EXIT  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LIMIT = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_LIMIT = CFG_IDX_W'(7);

  // Shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Datapath widths
  localparam int ACC_W  = 24;   // clamped integral, percent Q8.16
  localparam int STEP_W = 41;   // integral step magnitude, capped at 2^40
  localparam int SUM_W  = 43;   // integral plus signed step
  localparam int CMD_W  = 34;   // P term plus integral
  localparam int MAG_W  = 23;   // clamped command magnitude
  localparam int CNT_W  = 17;   // saturation counter

  localparam int STEP_SHIFT = 10;
  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(1) << (STEP_W - 1);

  localparam int PCT_FULL = 6553600;
  localparam int PCT_HALF = PCT_FULL / 2;

  // x / 200 as (x * DIV200_MUL) >> DIV200_SHIFT, exact for x < 2^23
  localparam int DIV200_SHIFT = 31;
  localparam longint DIV200_MUL = ((64'd1 << DIV200_SHIFT) + 199) / 200;

  // Integral limit defaults
  localparam int THROTTLE_INT_MAX_DEF = 6553600;
  localparam int THROTTLE_INT_MIN_DEF = 0;
  localparam int BRAKE_INT_MAX_DEF    = 0;
  localparam int BRAKE_INT_MIN_DEF    = -6553600;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP     = 2'd0,
    MODE_THROTTLE = 2'd1,
    MODE_BRAKE    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_DT,
    ST_ACCUM,
    ST_SUM,
    ST_SCALE,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/msp_mul.sv -----
// Shared unsigned multiplier with a registered product.
module msp_mul (
  input  logic                         clk_i,
  input  logic [msp_pkg::MUL_W-1:0]    a_i,
  input  logic [msp_pkg::MUL_W-1:0]    b_i,
  output logic [msp_pkg::PROD_W-1:0]   prod_o
);

  logic [msp_pkg::PROD_W-1:0] prod_q;
  logic [msp_pkg::PROD_W-1:0] prod_d;

  assign prod_d = msp_pkg::PROD_W'(a_i) * msp_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/mode_switch_speed_pi.sv -----
// Top level of the mode-switching throttle/brake PI speed controller.
//
// Use:
//   Slave stream takes one control tick per word: tdata carries desired speed,
//   measured velocity and tick time; tuser carries the stale flag. A stale
//   word is taken and dropped: no result, no state change. Every other word
//   gives exactly one result word on the master stream: throttle level, brake
//   level and the mode after the step.
//   Gains, exit errors and saturation limits are written through the cfg port
//   (one register per cycle, no read-back) while no tick is in flight.
// Sequencing:
//   One 32x32 multiplier is shared by all products (integral gain, elapsed
//   time, proportional gain, scale by 1/200) under a small sequencer, one
//   product per cycle. A PI step runs through decide, multiply by dt,
//   accumulate, sum, scale and done with tready low, and takes no new tick
//   until it is back in idle. Stop mode, code 3 and threshold exits skip the
//   PI products and go from decide to scale and done. Stale words are dropped.
// Reset and stall:
//   rst_ni clears config, state and output valid, sets mode and previous mode
//   to stop, integrals, stamps and counters to zero. The result sits in an
//   output register; if the receiver stalls, a new tick is still taken and
//   computed, then waits in its last step until the output register frees up.
module mode_switch_speed_pi #(
  parameter int THROTTLE_INT_MAX = msp_pkg::THROTTLE_INT_MAX_DEF,
  parameter int THROTTLE_INT_MIN = msp_pkg::THROTTLE_INT_MIN_DEF,
  parameter int BRAKE_INT_MAX    = msp_pkg::BRAKE_INT_MAX_DEF,
  parameter int BRAKE_INT_MIN    = msp_pkg::BRAKE_INT_MIN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msp_pkg::REG_W-1:0]           cfg_data_i,
  // tick stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [14:0] desired_speed, [30:15] measured_velocity, [62:31] tick_time, pad
  input  logic [msp_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // [0] inputs_stale
  input  logic                                s_axis_tuser_i,
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [15:0] throttle_level, [31:16] brake_level, [33:32] mode_now, pad
  output logic [msp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int SPEED_W   = msp_pkg::SPEED_W;
  localparam int DESIRED_W = msp_pkg::DESIRED_W;
  localparam int TIME_W    = msp_pkg::TIME_W;
  localparam int ERR_W     = msp_pkg::ERR_W;
  localparam int MUL_W     = msp_pkg::MUL_W;
  localparam int PROD_W    = msp_pkg::PROD_W;
  localparam int ACC_W     = msp_pkg::ACC_W;
  localparam int STEP_W    = msp_pkg::STEP_W;
  localparam int SUM_W     = msp_pkg::SUM_W;
  localparam int CMD_W     = msp_pkg::CMD_W;
  localparam int MAG_W     = msp_pkg::MAG_W;
  localparam int CNT_W     = msp_pkg::CNT_W;
  localparam int LEVEL_W   = msp_pkg::LEVEL_W;
  localparam int SHIFTED_W = PROD_W - msp_pkg::STEP_SHIFT;

  localparam logic signed [SUM_W-1:0] THR_HI = SUM_W'(THROTTLE_INT_MAX);
  localparam logic signed [SUM_W-1:0] THR_LO = SUM_W'(THROTTLE_INT_MIN);
  localparam logic signed [SUM_W-1:0] BRK_HI = SUM_W'(BRAKE_INT_MAX);
  localparam logic signed [SUM_W-1:0] BRK_LO = SUM_W'(BRAKE_INT_MIN);

  localparam logic signed [CMD_W-1:0] PCT_CMD     = CMD_W'(msp_pkg::PCT_FULL);
  localparam logic signed [CMD_W-1:0] PCT_CMD_NEG = -CMD_W'(msp_pkg::PCT_FULL);
  localparam logic [MAG_W-1:0]        PCT_MAG     = MAG_W'(msp_pkg::PCT_FULL);
  localparam logic [MAG_W-1:0]        HALF_MAG    = MAG_W'(msp_pkg::PCT_HALF);
  localparam logic [LEVEL_W-1:0]      HALF_LEVEL  = LEVEL_W'(msp_pkg::PCT_HALF / 200);
  localparam logic [CNT_W-1:0]        CNT_MAX     = '1;

  // ---------------------------------------------------------------- config
  logic [msp_pkg::REG_W-1:0] cfg_q [msp_pkg::CFG_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < msp_pkg::CFG_NUM; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- input unpack
  logic [DESIRED_W-1:0]    in_desired;
  logic [SPEED_W-1:0]      in_meas;
  logic [TIME_W-1:0]       in_time;
  logic [ERR_W-1:0]        in_abs_meas;
  logic [ERR_W-1:0]        in_desired_ext;
  logic                    in_err_neg;
  logic [ERR_W-1:0]        in_err_mag;

  assign in_desired = s_axis_tdata_i[DESIRED_W-1:0];
  assign in_meas    = s_axis_tdata_i[DESIRED_W +: SPEED_W];
  assign in_time    = s_axis_tdata_i[DESIRED_W+SPEED_W +: TIME_W];

  // error = desired - |measured|, kept as sign and magnitude
  assign in_abs_meas    = in_meas[SPEED_W-1] ? (ERR_W'(0) - {in_meas[SPEED_W-1], in_meas})
                                             : {1'b0, in_meas};
  assign in_desired_ext = ERR_W'(in_desired);
  assign in_err_neg     = in_desired_ext < in_abs_meas;
  assign in_err_mag     = in_err_neg ? (in_abs_meas - in_desired_ext)
                                     : (in_desired_ext - in_abs_meas);

  // ---------------------------------------------------------------- registers
  msp_pkg::state_e state_q, state_d;
  msp_pkg::mode_e  mode_q, prev_mode_q, eff_mode;

  logic                      desired_zero_q;
  logic                      err_neg_q;
  logic [ERR_W-1:0]          err_mag_q;
  logic [TIME_W-1:0]         now_q;
  logic                      brk_q;       // brake path (or stop: level on brake side)
  logic [MAG_W-1:0]          cmd_mag_q;

  logic signed [ACC_W-1:0]   thr_acc_q, brk_acc_q;
  logic [TIME_W-1:0]         thr_stamp_q, brk_stamp_q;
  logic [CNT_W-1:0]          thr_cnt_q, brk_cnt_q;

  logic                      out_valid_q;
  logic [LEVEL_W-1:0]        out_thr_q, out_brk_q;
  msp_pkg::mode_e            out_mode_q;

  // ---------------------------------------------------------------- shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;

  msp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  // ---------------------------------------------------------------- datapath
  logic                       thr_exit, brk_exit;
  logic signed [ACC_W-1:0]    acc_sel;
  logic [TIME_W-1:0]          stamp_sel;
  logic [CNT_W-1:0]           cnt_sel;
  logic [TIME_W-1:0]          dt;
  logic [SHIFTED_W-1:0]       shifted;
  logic [STEP_W-1:0]          step_mag;
  logic signed [STEP_W:0]     step_s;
  logic signed [SUM_W-1:0]    acc_sum, acc_clamp, lim_lo, lim_hi;
  logic signed [ACC_W-1:0]    acc_new;
  logic signed [CMD_W-1:0]    pterm, cmd;
  logic                       cnt_up, sat_exit;
  logic [CNT_W-1:0]           cnt_new;
  logic [msp_pkg::REG_W-1:0]  sat_lim;
  logic [MAG_W-1:0]           cmd_mag_new;
  logic [LEVEL_W-1:0]         level;
  logic                       out_free;

  assign eff_mode = desired_zero_q ? msp_pkg::MODE_STOP : mode_q;

  assign thr_exit = err_neg_q && (err_mag_q > ERR_W'(cfg_q[msp_pkg::CFG_THR_EXIT]));
  assign brk_exit = !err_neg_q && (err_mag_q > ERR_W'(cfg_q[msp_pkg::CFG_BRK_EXIT]));

  assign acc_sel   = brk_q ? brk_acc_q : thr_acc_q;
  assign stamp_sel = brk_q ? brk_stamp_q : thr_stamp_q;
  assign cnt_sel   = brk_q ? brk_cnt_q : thr_cnt_q;
  assign dt        = now_q - stamp_sel;

  // integral step: floor(ki * |err| * dt / 1024), capped at 2^40
  assign shifted  = mul_prod[PROD_W-1:msp_pkg::STEP_SHIFT];
  assign step_mag = (shifted > SHIFTED_W'(msp_pkg::STEP_CAP)) ? msp_pkg::STEP_CAP
                                                              : shifted[STEP_W-1:0];
  assign step_s   = err_neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
  assign acc_sum  = SUM_W'(acc_sel) + SUM_W'(step_s);
  assign lim_lo   = brk_q ? BRK_LO : THR_LO;
  assign lim_hi   = brk_q ? BRK_HI : THR_HI;

  // low limit is tested first; with crossed limits, sums below it take it, all others the high limit
  always_comb begin
    if (acc_sum < lim_lo) begin
      acc_clamp = lim_lo;
    end else if (acc_sum > lim_hi) begin
      acc_clamp = lim_hi;
    end else begin
      acc_clamp = acc_sum;
    end
  end
  assign acc_new = ACC_W'(acc_clamp);

  // command = kp * err + integral
  assign pterm = $signed({2'b00, mul_prod[MUL_W-1:0]});
  assign cmd   = (err_neg_q ? -pterm : pterm) + CMD_W'(acc_sel);

  assign cnt_up  = brk_q ? (cmd > 0) : (cmd < 0);
  always_comb begin
    if (cnt_up) begin
      cnt_new = (cnt_sel == CNT_MAX) ? cnt_sel : cnt_sel + CNT_W'(1);
    end else begin
      cnt_new = (cnt_sel == '0) ? cnt_sel : cnt_sel - CNT_W'(1);
    end
  end
  assign sat_lim  = brk_q ? cfg_q[msp_pkg::CFG_BRK_LIMIT] : cfg_q[msp_pkg::CFG_THR_LIMIT];
  assign sat_exit = cnt_new > CNT_W'(sat_lim);

  always_comb begin
    cmd_mag_new = '0;
    if (!sat_exit) begin
      if (!brk_q) begin
        if (cmd < 0) begin
          cmd_mag_new = '0;
        end else if (cmd > PCT_CMD) begin
          cmd_mag_new = PCT_MAG;
        end else begin
          cmd_mag_new = cmd[MAG_W-1:0];
        end
      end else begin
        if (cmd > 0) begin
          cmd_mag_new = '0;
        end else if (cmd < PCT_CMD_NEG) begin
          cmd_mag_new = PCT_MAG;
        end else begin
          cmd_mag_new = MAG_W'(-cmd);
        end
      end
    end
  end

  assign level    = mul_prod[msp_pkg::DIV200_SHIFT +: LEVEL_W];
  assign out_free = !out_valid_q || m_axis_tready_i;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    mul_a           = MUL_W'(cmd_mag_q);
    mul_b           = MUL_W'(msp_pkg::DIV200_MUL);
    case (state_q)
      msp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && !s_axis_tuser_i) begin
          state_d = msp_pkg::ST_DECIDE;
        end
      end
      msp_pkg::ST_DECIDE: begin
        // ki * |err|
        mul_a = MUL_W'((eff_mode == msp_pkg::MODE_BRAKE) ? cfg_q[msp_pkg::CFG_BRK_KI]
                                                         : cfg_q[msp_pkg::CFG_THR_KI]);
        mul_b = MUL_W'(err_mag_q);
        if ((eff_mode == msp_pkg::MODE_THROTTLE && !thr_exit) ||
            (eff_mode == msp_pkg::MODE_BRAKE && !brk_exit)) begin
          state_d = msp_pkg::ST_MUL_DT;
        end else begin
          state_d = msp_pkg::ST_SCALE;
        end
      end
      msp_pkg::ST_MUL_DT: begin
        mul_a   = mul_prod[MUL_W-1:0];
        mul_b   = MUL_W'(dt);
        state_d = msp_pkg::ST_ACCUM;
      end
      msp_pkg::ST_ACCUM: begin
        mul_a   = MUL_W'(brk_q ? cfg_q[msp_pkg::CFG_BRK_KP] : cfg_q[msp_pkg::CFG_THR_KP]);
        mul_b   = MUL_W'(err_mag_q);
        state_d = msp_pkg::ST_SUM;
      end
      msp_pkg::ST_SUM: begin
        state_d = msp_pkg::ST_SCALE;
      end
      msp_pkg::ST_SCALE: begin
        state_d = msp_pkg::ST_DONE;
      end
      msp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = msp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msp_pkg::ST_IDLE;
      end
    endcase
  end

  // tick latch and scratch values
  always_ff @(posedge clk_i) begin
    if (state_q == msp_pkg::ST_IDLE && s_axis_tvalid_i) begin
      desired_zero_q <= (in_desired == '0);
      err_neg_q      <= in_err_neg;
      err_mag_q      <= in_err_mag;
      now_q          <= in_time;
    end
    case (state_q)
      msp_pkg::ST_DECIDE: begin
        brk_q <= (eff_mode != msp_pkg::MODE_THROTTLE);
        if ((eff_mode == msp_pkg::MODE_THROTTLE && thr_exit) ||
            (eff_mode == msp_pkg::MODE_BRAKE && brk_exit)) begin
          cmd_mag_q <= '0;
        end else begin
          cmd_mag_q <= HALF_MAG;   // stop mode; PI path overwrites it later
        end
      end
      msp_pkg::ST_SUM: begin
        cmd_mag_q <= cmd_mag_new;
      end
      default: begin
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= msp_pkg::MODE_STOP;
      prev_mode_q <= msp_pkg::MODE_STOP;
      thr_acc_q   <= '0;
      brk_acc_q   <= '0;
      thr_stamp_q <= '0;
      brk_stamp_q <= '0;
      thr_cnt_q   <= '0;
      brk_cnt_q   <= '0;
    end else begin
      case (state_q)
        msp_pkg::ST_DECIDE: begin
          prev_mode_q <= eff_mode;
          case (eff_mode)
            msp_pkg::MODE_STOP: begin
              mode_q <= desired_zero_q ? msp_pkg::MODE_STOP : msp_pkg::MODE_BRAKE;
            end
            msp_pkg::MODE_THROTTLE: begin
              if (prev_mode_q != msp_pkg::MODE_THROTTLE) begin
                thr_acc_q   <= '0;
                thr_stamp_q <= now_q;
                thr_cnt_q   <= '0;
              end
              if (thr_exit) begin
                mode_q <= msp_pkg::MODE_BRAKE;
              end
            end
            msp_pkg::MODE_BRAKE: begin
              if (prev_mode_q != msp_pkg::MODE_BRAKE) begin
                brk_acc_q   <= '0;
                brk_stamp_q <= now_q;
                brk_cnt_q   <= '0;
              end
              if (brk_exit) begin
                mode_q <= msp_pkg::MODE_THROTTLE;
              end
            end
            default: begin
            end
          endcase
        end
        msp_pkg::ST_ACCUM: begin
          if (brk_q) begin
            brk_acc_q   <= acc_new;
            brk_stamp_q <= now_q;
          end else begin
            thr_acc_q   <= acc_new;
            thr_stamp_q <= now_q;
          end
        end
        msp_pkg::ST_SUM: begin
          if (brk_q) begin
            brk_cnt_q <= cnt_new;
            if (sat_exit) begin
              mode_q <= msp_pkg::MODE_THROTTLE;
            end
          end else begin
            thr_cnt_q <= cnt_new;
            if (sat_exit) begin
              mode_q <= msp_pkg::MODE_BRAKE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == msp_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == msp_pkg::ST_DONE && out_free) begin
      out_thr_q  <= brk_q ? '0 : level;
      out_brk_q  <= brk_q ? level : '0;
      out_mode_q <= mode_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = msp_pkg::OUT_DATA_W'({out_mode_q, out_brk_q, out_thr_q});

`ifndef NO_ASSERTIONS
  // a stale tick never starts the sequencer
  a_stale_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> (state_q == msp_pkg::ST_IDLE))
    else $error("stale tick started a step");

  // a new result only comes out of the final step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == msp_pkg::ST_DONE))
    else $error("result appeared outside the final step");

  // stop mode always reports half brake and no throttle
  a_stop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_mode_q == msp_pkg::MODE_STOP) |->
      (out_brk_q == HALF_LEVEL && out_thr_q == '0))
    else $error("stop mode result is not half brake");
`endif

endmodule

// ----- test/mode_switch_speed_pi_tb.sv -----
// Self-checking testbench for the mode-switching throttle/brake PI speed controller.
module mode_switch_speed_pi_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  // Expected content of one result word
  typedef struct {
    logic [LEVEL_W-1:0] throttle;
    logic [LEVEL_W-1:0] brake;
    mode_e              mode;
  } levels_t;

  typedef bit [REG_W-1:0] settings_t [CFG_NUM];

  // Register profiles used across the run
  typedef enum int {
    PROF_DIRECTED,
    PROF_MODERATE,
    PROF_ZERO,
    PROF_FULL,
    PROF_TIGHT,
    PROF_RANDOM
  } profile_e;

  localparam profile_e RUN_PLAN [6] = '{PROF_MODERATE, PROF_ZERO, PROF_FULL,
                                        PROF_TIGHT, PROF_RANDOM, PROF_MODERATE};
  localparam int TICKS_PER_PHASE = 190;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int SQUEEZE_AT      = 500;  // accepted ticks before the long sink stall
  localparam int SQUEEZE_CYCLES  = 300;
  localparam int IDLE_PCT        = 7;
  localparam longint unsigned STEP_LIMIT = 64'd1 << 40;
  localparam int unsigned SAT_COUNT_MAX = (1 << CNT_W) - 1;

  // Tracks controller state and the queue of result words still owed by the block
  class level_scoreboard;
    bit [REG_W-1:0] regs [CFG_NUM];
    mode_e          mode;
    mode_e          prior_mode;
    longint         thr_int;
    longint         brk_int;
    bit [TIME_W-1:0] thr_stamp;
    bit [TIME_W-1:0] brk_stamp;
    int unsigned    thr_sat;
    int unsigned    brk_sat;
    levels_t        expected_levels [$];
    int             errors;
    int             results_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mode = MODE_STOP;
      prior_mode = MODE_STOP;
      thr_int = 0;
      brk_int = 0;
      thr_stamp = '0;
      brk_stamp = '0;
      thr_sat = 0;
      brk_sat = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(int idx, bit [REG_W-1:0] value);
      regs[idx] = value;
    endfunction

    function longint limit_range(longint lo, longint v, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // gain * |err| * dt / 1024, magnitude floored and capped at 2^40
    function longint integral_step(bit [REG_W-1:0] gain, longint err, bit [TIME_W-1:0] dt);
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned step;
      mag = (err < 0) ? -err : err;
      prod = 64'(gain) * mag;
      if (prod == 0) return 0;
      if (64'(dt) > ((64'd1 << 50) / prod)) begin
        step = STEP_LIMIT;
      end else begin
        step = (prod * 64'(dt)) >> STEP_SHIFT;
        if (step > STEP_LIMIT) step = STEP_LIMIT;
      end
      return (err < 0) ? -longint'(step) : longint'(step);
    endfunction

    function longint run_throttle(bit [TIME_W-1:0] now, longint err);
      longint cmd;
      bit [TIME_W-1:0] dt;
      if (prior_mode != MODE_THROTTLE) begin
        thr_int = 0;
        thr_stamp = now;
        thr_sat = 0;
      end
      if (err < -longint'(regs[CFG_THR_EXIT])) begin
        mode = MODE_BRAKE;
        return 0;
      end
      dt = now - thr_stamp;
      thr_stamp = now;
      thr_int = limit_range(THROTTLE_INT_MIN_DEF,
                            thr_int + integral_step(regs[CFG_THR_KI], err, dt),
                            THROTTLE_INT_MAX_DEF);
      cmd = longint'(regs[CFG_THR_KP]) * err + thr_int;
      if (cmd < 0) begin
        if (thr_sat < SAT_COUNT_MAX) thr_sat++;
      end else if (thr_sat > 0) begin
        thr_sat--;
      end
      if (thr_sat > regs[CFG_THR_LIMIT]) begin
        mode = MODE_BRAKE;
        cmd = 0;
      end
      return limit_range(0, cmd, PCT_FULL);
    endfunction

    function longint run_brake(bit [TIME_W-1:0] now, longint err);
      longint cmd;
      bit [TIME_W-1:0] dt;
      if (prior_mode != MODE_BRAKE) begin
        brk_int = 0;
        brk_stamp = now;
        brk_sat = 0;
      end
      if (err > longint'(regs[CFG_BRK_EXIT])) begin
        mode = MODE_THROTTLE;
        return 0;
      end
      dt = now - brk_stamp;
      brk_stamp = now;
      brk_int = limit_range(BRAKE_INT_MIN_DEF,
                            brk_int + integral_step(regs[CFG_BRK_KI], err, dt),
                            BRAKE_INT_MAX_DEF);
      cmd = longint'(regs[CFG_BRK_KP]) * err + brk_int;
      if (cmd > 0) begin
        if (brk_sat < SAT_COUNT_MAX) brk_sat++;
      end else if (brk_sat > 0) begin
        brk_sat--;
      end
      if (brk_sat > regs[CFG_BRK_LIMIT]) begin
        mode = MODE_THROTTLE;
        cmd = 0;
      end
      return limit_range(-longint'(PCT_FULL), cmd, 0);
    endfunction

    // Called for every accepted tick word; stale ticks leave no trace
    function void note_tick(bit [DESIRED_W-1:0] desired, bit [SPEED_W-1:0] velocity,
                            bit [TIME_W-1:0] now, bit stale);
      longint  speed;
      longint  err;
      longint  cmd;
      mode_e   entry;
      levels_t want;
      if (stale) return;
      speed = longint'(signed'(velocity));
      if (speed < 0) speed = -speed;
      err = longint'(desired) - speed;
      if (desired == 0) mode = MODE_STOP;
      entry = mode;
      cmd = -longint'(PCT_HALF);
      case (mode)
        MODE_STOP: begin
          if (desired != 0) mode = MODE_BRAKE;
        end
        MODE_THROTTLE: cmd = run_throttle(now, err);
        MODE_BRAKE:    cmd = run_brake(now, err);
        default: ;
      endcase
      prior_mode = entry;
      want.throttle = (cmd > 0) ? LEVEL_W'(cmd / 200) : '0;
      want.brake    = (cmd < 0) ? LEVEL_W'((-cmd) / 200) : '0;
      want.mode     = mode;
      expected_levels.push_back(want);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_levels(logic [OUT_DATA_W-1:0] word);
      levels_t            want;
      logic [LEVEL_W-1:0] got_thr;
      logic [LEVEL_W-1:0] got_brk;
      logic [MODE_W-1:0]  got_mode;
      got_thr  = word[LEVEL_W-1:0];
      got_brk  = word[2*LEVEL_W-1:LEVEL_W];
      got_mode = word[2*LEVEL_W+MODE_W-1:2*LEVEL_W];
      results_seen++;
      if (expected_levels.size() == 0) begin
        flag($sformatf("result %0d arrived with none pending, word %h", results_seen, word));
        return;
      end
      want = expected_levels.pop_front();
      if (got_thr !== want.throttle)
        flag($sformatf("result %0d throttle_level exp %0d got %0d",
                       results_seen, want.throttle, got_thr));
      if (got_brk !== want.brake)
        flag($sformatf("result %0d brake_level exp %0d got %0d",
                       results_seen, want.brake, got_brk));
      if (got_mode !== want.mode)
        flag($sformatf("result %0d mode_now exp %0d got %0d",
                       results_seen, want.mode, got_mode));
    endfunction
  endclass

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Block inputs, known from time zero
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data  = '0;
  logic                  s_valid   = 1'b0;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic                  s_stale   = 1'b0;
  logic                  m_ready   = 1'b0;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  mode_switch_speed_pi i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_stale),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  level_scoreboard sb = new();

  int              ticks_taken  = 0;        // tick words accepted so far, stale included
  bit              squeeze_req  = 1'b0;     // asks the sink for its long stall
  bit [DESIRED_W-1:0] cruise_speed = 15'h0200;
  bit [TIME_W-1:0]    cruise_time  = '0;
  int              stall_cycles = 0;

  // Register profile for one phase. Moderate keeps the loops near balance, tight
  // makes saturation and threshold exits frequent, zero and full are the extremes.
  function automatic settings_t pick_settings(profile_e kind);
    settings_t s;
    case (kind)
      PROF_DIRECTED: begin
        s[CFG_THR_KP]    = 16'h0400;
        s[CFG_THR_KI]    = 16'h0100;
        s[CFG_BRK_KP]    = 16'h0400;
        s[CFG_BRK_KI]    = 16'h0100;
        s[CFG_THR_EXIT]  = 16'h0080;
        s[CFG_BRK_EXIT]  = 16'h0080;
        s[CFG_THR_LIMIT] = 16'd3;
        s[CFG_BRK_LIMIT] = 16'd3;
      end
      PROF_ZERO:   foreach (s[i]) s[i] = '0;
      PROF_FULL:   foreach (s[i]) s[i] = '1;
      PROF_RANDOM: foreach (s[i]) s[i] = REG_W'($urandom);
      PROF_TIGHT: begin
        s[CFG_THR_KP]    = REG_W'($urandom);
        s[CFG_THR_KI]    = REG_W'($urandom);
        s[CFG_BRK_KP]    = REG_W'($urandom);
        s[CFG_BRK_KI]    = REG_W'($urandom);
        s[CFG_THR_EXIT]  = REG_W'($urandom_range(0, 64));
        s[CFG_BRK_EXIT]  = REG_W'($urandom_range(0, 64));
        s[CFG_THR_LIMIT] = REG_W'($urandom_range(0, 2));
        s[CFG_BRK_LIMIT] = REG_W'($urandom_range(0, 2));
      end
      default: begin
        s[CFG_THR_KP]    = REG_W'($urandom_range(0, 16'h2000));
        s[CFG_THR_KI]    = REG_W'($urandom_range(0, 16'h2000));
        s[CFG_BRK_KP]    = REG_W'($urandom_range(0, 16'h2000));
        s[CFG_BRK_KI]    = REG_W'($urandom_range(0, 16'h2000));
        s[CFG_THR_EXIT]  = REG_W'($urandom_range(0, 16'h0400));
        s[CFG_BRK_EXIT]  = REG_W'($urandom_range(0, 16'h0400));
        s[CFG_THR_LIMIT] = REG_W'($urandom_range(0, 20));
        s[CFG_BRK_LIMIT] = REG_W'($urandom_range(0, 20));
      end
    endcase
    return s;
  endfunction

  // One register per edge; the block must be idle
  task automatic load_settings(settings_t s);
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= s[i];
      @(posedge clk_i);
      sb.set_reg(i, s[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one tick word; valid stays high after acceptance so back-to-back
  // words never see a low-then-high in the same step.
  task automatic send_tick(bit [DESIRED_W-1:0] desired, bit [SPEED_W-1:0] velocity,
                           bit [TIME_W-1:0] now, bit stale);
    bit quiet;
    quiet = (ticks_taken >= 300 && ticks_taken < 450);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, now, velocity, desired};
    s_stale <= stale;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_tick(desired, velocity, now, stale);
    ticks_taken++;
    if (ticks_taken == SQUEEZE_AT) squeeze_req = 1'b1;
  endtask

  // Drop valid, wait for every owed word, then let a dropped stale tick drain
  task automatic finish_phase();
    s_valid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly plausible driving: a cruise speed held for a while, velocity near it,
  // time moving forward in small steps. Mixed in: stale words, pure noise,
  // stop requests, reversing, and big jumps in time.
  task automatic drive_random(int wanted);
    int taken;
    int pick;
    int spread;
    int speed;
    bit [DESIRED_W-1:0] d;
    bit [SPEED_W-1:0]   v;
    bit [TIME_W-1:0]    t;
    bit                 st;
    taken = 0;
    while (taken < wanted) begin
      pick = $urandom_range(99);
      st = 1'b0;
      if (pick < 5) begin
        d  = DESIRED_W'($urandom);
        v  = SPEED_W'($urandom);
        t  = $urandom;
        st = 1'b1;
      end else if (pick < 9) begin
        d = DESIRED_W'($urandom);
        v = SPEED_W'($urandom);
        t = $urandom;
      end else if (pick < 13) begin
        cruise_time += $urandom_range(1, 200);
        d = '0;
        v = SPEED_W'($urandom_range(0, 2048));
        t = cruise_time;
      end else begin
        if ($urandom_range(15) == 0)
          cruise_speed = ($urandom_range(3) == 0) ? DESIRED_W'($urandom_range(1, 32767))
                                                  : DESIRED_W'($urandom_range(1, 4096));
        cruise_time += ($urandom_range(49) == 0) ? $urandom : $urandom_range(1, 256);
        case ($urandom_range(2))
          0:       spread = 16;
          1:       spread = 256;
          default: spread = 4096;
        endcase
        speed = int'(cruise_speed) + int'($urandom_range(0, 2 * spread)) - spread;
        if (speed < 0) speed = -speed;
        if (speed > 32767) speed = 32767;
        if ($urandom_range(9) == 0) speed = -speed;   // reversing: magnitude counts
        d = cruise_speed;
        v = SPEED_W'(speed);
        t = cruise_time;
      end
      send_tick(d, v, t, st);
      if (!st) taken++;
    end
  endtask

  // Result sink: random stalls, a quiet window, and one long hold-off while the
  // source keeps offering so the block fills and drops tready.
  initial begin : result_sink
    int hold_left;
    bit squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) sb.check_levels(m_axis_tdata_o);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (sb.results_seen >= 600 && sb.results_seen < 800) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any accepted word or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed ticks with hand-picked gains: exit errors of 0.5 m/s, limits of 3
    load_settings(pick_settings(PROF_DIRECTED));
    send_tick(15'h0000, 16'h0000, 32'd0, 1'b0);          // zero speed holds stop
    send_tick(15'h0200, 16'h0200, 32'd16, 1'b1);         // stale: dropped, nothing moves
    send_tick(15'h0200, 16'h0200, 32'd32, 1'b0);         // stop gives half brake, enters brake
    send_tick(15'h0200, 16'h0240, 32'd48, 1'b0);         // brake entry clears loop, overspeed
    send_tick(15'h0200, 16'h0240, 32'd80, 1'b0);
    send_tick(15'h0200, 16'hFE40, 32'd96, 1'b0);         // reverse, slight underspeed
    send_tick(15'h0200, 16'h01C0, 32'd112, 1'b0);        // positive brake command counts up
    send_tick(15'h0200, 16'h01C0, 32'd128, 1'b0);
    send_tick(15'h0200, 16'h01C0, 32'd144, 1'b0);        // count passes limit: to throttle
    send_tick(15'h0200, 16'h0000, 32'd160, 1'b0);        // throttle entry
    send_tick(15'h7FFF, 16'h0000, 32'h4000_0000, 1'b0);  // huge dt: step capped, integral clamps
    send_tick(15'h7FFF, 16'h7FFF, 32'h4000_0100, 1'b0);  // zero error
    send_tick(15'h0100, 16'h7FFF, 32'h4000_0200, 1'b0);  // big overspeed: threshold to brake
    send_tick(15'h0100, 16'h8000, 32'h4000_0300, 1'b0);  // most negative velocity
    send_tick(15'h0100, 16'h0100, 32'hFFFF_FFF0, 1'b0);  // long dt in brake
    send_tick(15'h0100, 16'h0100, 32'h0000_0010, 1'b0);  // time wraps
    send_tick(15'h7FFF, 16'h0000, 32'h0000_0020, 1'b0);  // big underspeed: threshold to throttle
    send_tick(15'h0000, 16'h7FFF, 32'h0000_0030, 1'b0);  // zero speed forces stop
    send_tick(15'h0001, 16'hFFFF, 32'h0000_0040, 1'b0);  // smallest speed leaves stop
    send_tick(15'h0001, 16'h0001, 32'h0000_0050, 1'b0);
    send_tick(15'h7FFF, 16'h8000, 32'hFFFF_FFFF, 1'b1);  // stale with every field at an extreme
    send_tick(15'h4000, 16'h4000, 32'hFFFF_FFFF, 1'b0);
    finish_phase();

    foreach (RUN_PLAN[k]) begin
      load_settings(pick_settings(RUN_PLAN[k]));
      drive_random(TICKS_PER_PHASE);
      finish_phase();
    end

    if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/msp_pkg.sv
rtl/msp_mul.sv
rtl/mode_switch_speed_pi.sv
test/mode_switch_speed_pi_tb.sv
